FILE: rtl/mm_pkg.sv
// Shared constants, codes and types for the matrix multiplier.
// Used by every module of the block but mm_ram; depends on nothing.
package mm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_W_DEF  = 16;

    localparam int VALUE_W  = 16;
    localparam int EXT_W    = 32;
    localparam int ROWCOL_W = 3;
    localparam int DIM_W    = 4;
    localparam int PROD_W   = 40;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] OP_WR_A = 2'd0;
    localparam logic [1:0] OP_WR_B = 2'd1;
    localparam logic [1:0] OP_MUL  = 2'd2;

    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_B_COLS = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RST = 4'd8;

    // Control that travels with each A element down the chain.
    typedef struct packed {
        logic vld;
        logic first;
        logic lastk;
    } t_ctl;

    // Dimension register to "count minus one", with zero read as one and
    // anything above the maximum read as the maximum.
    function automatic logic [DIM_W-1:0] dim_m1(input logic [DIM_W-1:0] d,
                                                input logic [DIM_W-1:0] max_d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = '0;
        end else if (d > max_d) begin
            r = max_d - 1'b1;
        end else begin
            r = d - 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mm_cell.sv
// One column cell of the multiplier chain: holds one column of B, multiplies
// the passing A element by its B entry and accumulates. Depends on mm_pkg.
module mm_cell #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mm_pkg::ELEM_W_DEF,
    parameter int COL        = 0,
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mm_pkg::t_ctl                 i_ctl,
    input  logic [IDX_W-1:0]             i_k,
    input  logic signed [ELEM_WIDTH-1:0] i_a,
    input  logic                         i_bwr_en,
    input  logic [IDX_W-1:0]             i_bwr_row,
    input  logic [IDX_W-1:0]             i_bwr_col,
    input  logic [ELEM_WIDTH-1:0]        i_bwr_data,
    output mm_pkg::t_ctl                 o_ctl,
    output logic [IDX_W-1:0]             o_k,
    output logic signed [ELEM_WIDTH-1:0] o_a,
    output logic                         o_done,
    output logic [mm_pkg::PROD_W-1:0]    o_acc
);

    logic signed [ELEM_WIDTH-1:0]   r_b [MAX_DIM];
    mm_pkg::t_ctl                   r_ctl;
    logic [IDX_W-1:0]               r_k;
    logic signed [ELEM_WIDTH-1:0]   r_a;
    mm_pkg::t_ctl                   r_pctl;
    logic signed [2*ELEM_WIDTH-1:0] r_prod;
    logic [mm_pkg::PROD_W-1:0]      r_acc;
    logic                           r_done;
    logic signed [2*ELEM_WIDTH-1:0] n_prod;
    logic [mm_pkg::PROD_W-1:0]      n_acc;

    always_ff @(posedge i_clk) begin
        if (i_bwr_en && (i_bwr_col == IDX_W'(COL))) begin
            r_b[i_bwr_row] <= i_bwr_data;
        end
    end

    assign n_prod = i_a * r_b[i_k];

    // The product is cast to the result width (sign-extended at the default widths); the sum wraps.
    always_comb begin
        n_acc = mm_pkg::PROD_W'(r_prod);
        if (!r_pctl.first) begin
            n_acc = r_acc + mm_pkg::PROD_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_pctl <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_pctl <= i_ctl;
            r_done <= r_pctl.vld && r_pctl.lastk;
        end
        r_k    <= i_k;
        r_a    <= i_a;
        r_prod <= n_prod;
        if (r_pctl.vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_k    = r_k;
    assign o_a    = r_a;
    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

FILE: rtl/matrix_multiply.sv
// Top level of the integer matrix multiplier: APB registers, command sequencer,
// A element RAM and the chain of column cells. Depends on mm_pkg, mm_ram, mm_cell.
//
//  Channel   Direction  Handshake                     Payload
//  command   in         start & !busy                 i_opcode, i_row, i_col, i_value
//  result    out        o_valid (one cycle, no stall) o_out_row, o_out_col, o_product, o_last
//  config    in         APB write, psel&penable       paddr, pwdata (prdata on read)
//
// Element writes (opcode 0 and 1) leave busy low. In a compute row, A elements are read
// from the RAM one per cycle into the cell chain and the column sums drain one per cycle.
// After the last row the sequencer waits while the A stream clears the unused cells.
// Reset sets all three dimensions to 8; the element stores are not cleared.
// Results cannot be stalled; within a row they come on consecutive cycles.
module matrix_multiply #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mm_pkg::ELEM_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_opcode,
    input  logic [mm_pkg::ROWCOL_W-1:0]       i_row,
    input  logic [mm_pkg::ROWCOL_W-1:0]       i_col,
    input  logic signed [mm_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    output logic [mm_pkg::ROWCOL_W-1:0]       o_out_row,
    output logic [mm_pkg::ROWCOL_W-1:0]       o_out_col,
    output logic signed [mm_pkg::PROD_W-1:0]  o_product,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mm_pkg::PADDR_W-1:0]        paddr,
    input  logic [mm_pkg::PDATA_W-1:0]        pwdata,
    output logic [mm_pkg::PDATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int A_DEPTH = 2 ** (2 * IDX_W);
    localparam logic [mm_pkg::DIM_W-1:0] MAX_DIM_V = mm_pkg::DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_FLUSH
    } t_state;

    // Configuration registers.
    logic [mm_pkg::DIM_W-1:0] r_a_rows;
    logic [mm_pkg::DIM_W-1:0] r_inner;
    logic [mm_pkg::DIM_W-1:0] r_b_cols;
    logic                     cfg_wr;

    // Sequencer.
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_s, n_s;
    logic [IDX_W-1:0] r_nrm1, n_nrm1;
    logic [IDX_W-1:0] r_nkm1, n_nkm1;
    logic [IDX_W-1:0] r_ncm1, n_ncm1;
    mm_pkg::t_ctl     r_rd_ctl, n_rd_ctl;
    logic [IDX_W-1:0] r_rd_k, n_rd_k;

    // Command decode.
    logic                  cmd_acc;
    logic                  idx_ok;
    logic [mm_pkg::EXT_W-1:0] val_ext;
    logic [ELEM_WIDTH-1:0] elem;
    logic                  a_we;
    logic                  b_we;
    logic [ELEM_WIDTH-1:0] a_rdata;

    // Chain.
    mm_pkg::t_ctl                 c_ctl [MAX_DIM];
    logic [IDX_W-1:0]             c_k   [MAX_DIM];
    logic signed [ELEM_WIDTH-1:0] c_a   [MAX_DIM];
    logic [MAX_DIM-1:0]           done_vec;
    logic [mm_pkg::PROD_W-1:0]    acc_vec [MAX_DIM];

    // Output stage.
    logic                      emit;
    logic [mm_pkg::PROD_W-1:0] emit_prod;
    logic [IDX_W-1:0]          r_ocol;
    logic                      r_o_valid;
    logic [IDX_W-1:0]          r_o_row;
    logic [IDX_W-1:0]          r_o_col;
    logic [mm_pkg::PROD_W-1:0] r_o_product;
    logic                      r_o_last;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= mm_pkg::DIM_RST;
            r_inner  <= mm_pkg::DIM_RST;
            r_b_cols <= mm_pkg::DIM_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                mm_pkg::REG_A_ROWS: r_a_rows <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_INNER:  r_inner  <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_B_COLS: r_b_cols <= pwdata[mm_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mm_pkg::REG_A_ROWS: prdata = mm_pkg::PDATA_W'(r_a_rows);
            mm_pkg::REG_INNER:  prdata = mm_pkg::PDATA_W'(r_inner);
            mm_pkg::REG_B_COLS: prdata = mm_pkg::PDATA_W'(r_b_cols);
            default:            prdata = '0;
        endcase
    end

    // ---------------- command decode ----------------
    assign busy    = (r_state != S_IDLE);
    assign cmd_acc = start && !busy;
    assign idx_ok  = (mm_pkg::DIM_W'(i_row) < MAX_DIM_V) &&
                     (mm_pkg::DIM_W'(i_col) < MAX_DIM_V);
    assign val_ext = mm_pkg::EXT_W'(i_value);
    assign elem    = val_ext[ELEM_WIDTH-1:0];
    assign a_we    = cmd_acc && idx_ok && (i_opcode == mm_pkg::OP_WR_A);
    assign b_we    = cmd_acc && idx_ok && (i_opcode == mm_pkg::OP_WR_B);

    mm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (A_DEPTH)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr ({i_row[IDX_W-1:0], i_col[IDX_W-1:0]}),
        .i_wdata (elem),
        .i_raddr ({r_i, r_s}),
        .o_rdata (a_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_s      = r_s;
        n_nrm1   = r_nrm1;
        n_nkm1   = r_nkm1;
        n_ncm1   = r_ncm1;
        n_rd_ctl = '0;
        n_rd_k   = r_s;
        case (r_state)
            S_IDLE: begin
                if (cmd_acc && (i_opcode == mm_pkg::OP_MUL)) begin
                    n_state = S_FEED;
                    n_i     = '0;
                    n_s     = '0;
                    n_nrm1  = IDX_W'(mm_pkg::dim_m1(r_a_rows, MAX_DIM_V));
                    n_nkm1  = IDX_W'(mm_pkg::dim_m1(r_inner, MAX_DIM_V));
                    n_ncm1  = IDX_W'(mm_pkg::dim_m1(r_b_cols, MAX_DIM_V));
                end
            end
            S_FEED: begin
                n_rd_ctl.vld   = 1'b1;
                n_rd_ctl.first = (r_s == '0);
                n_rd_ctl.lastk = (r_s == r_nkm1);
                if (r_s == r_nkm1) begin
                    n_s     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            S_DRAIN: begin
                // The last used column finishes last; the row is then complete.
                if (done_vec[r_ncm1]) begin
                    if (r_i != r_nrm1) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_FEED;
                    end else if (r_ncm1 == IDX_W'(MAX_DIM - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        // Let the A stream pass the unused cells so that no
                        // stale column sum is left when the next compute starts.
                        n_s     = r_ncm1 + 1'b1;
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (r_s == IDX_W'(MAX_DIM - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_ctl <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ctl <= n_rd_ctl;
        end
        r_i    <= n_i;
        r_s    <= n_s;
        r_nrm1 <= n_nrm1;
        r_nkm1 <= n_nkm1;
        r_ncm1 <= n_ncm1;
        r_rd_k <= n_rd_k;
    end

    // ---------------- cell chain ----------------
    assign c_ctl[0] = r_rd_ctl;
    assign c_k[0]   = r_rd_k;
    assign c_a[0]   = a_rdata;

    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        if (j < MAX_DIM - 1) begin : g_mid
            mm_cell #(
                .MAX_DIM    (MAX_DIM),
                .ELEM_WIDTH (ELEM_WIDTH),
                .COL        (j)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (c_ctl[j]),
                .i_k        (c_k[j]),
                .i_a        (c_a[j]),
                .i_bwr_en   (b_we),
                .i_bwr_row  (i_row[IDX_W-1:0]),
                .i_bwr_col  (i_col[IDX_W-1:0]),
                .i_bwr_data (elem),
                .o_ctl      (c_ctl[j+1]),
                .o_k        (c_k[j+1]),
                .o_a        (c_a[j+1]),
                .o_done     (done_vec[j]),
                .o_acc      (acc_vec[j])
            );
        end else begin : g_end
            mm_cell #(
                .MAX_DIM    (MAX_DIM),
                .ELEM_WIDTH (ELEM_WIDTH),
                .COL        (j)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (c_ctl[j]),
                .i_k        (c_k[j]),
                .i_a        (c_a[j]),
                .i_bwr_en   (b_we),
                .i_bwr_row  (i_row[IDX_W-1:0]),
                .i_bwr_col  (i_col[IDX_W-1:0]),
                .i_bwr_data (elem),
                .o_ctl      (),
                .o_k        (),
                .o_a        (),
                .o_done     (done_vec[j]),
                .o_acc      (acc_vec[j])
            );
        end
    end

    // ---------------- result stage ----------------
    // Within a row only one cell finishes per cycle; cells past the last used
    // column also finish but are masked out.
    always_comb begin
        emit      = 1'b0;
        emit_prod = '0;
        for (int j = 0; j < MAX_DIM; j++) begin
            if (done_vec[j] && (IDX_W'(j) <= r_ncm1)) begin
                emit      = 1'b1;
                emit_prod = acc_vec[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
            r_ocol    <= '0;
        end else begin
            r_o_valid <= emit;
            r_o_last  <= emit && (r_i == r_nrm1) && (r_ocol == r_ncm1);
            if (emit) begin
                r_ocol <= (r_ocol == r_ncm1) ? '0 : r_ocol + 1'b1;
            end
        end
        r_o_row     <= r_i;
        r_o_col     <= r_ocol;
        r_o_product <= emit_prod;
    end

    assign o_valid   = r_o_valid;
    assign o_out_row = mm_pkg::ROWCOL_W'(r_o_row);
    assign o_out_col = mm_pkg::ROWCOL_W'(r_o_col);
    assign o_product = r_o_product;
    assign o_last    = r_o_last;

endmodule

FILE: rtl/mm_checker.sv
// Port-level checks for the matrix multiplier, bound to the top level.
// Depends on mm_pkg and matrix_multiply.
module mm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  i_opcode,
    input logic                        o_valid,
    input logic                        o_last
);

    // A compute transaction must lock out further commands.
    a_mul_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == mm_pkg::OP_MUL)) |=> busy)
        else $error("busy not raised after compute command");

    // Commands other than compute leave busy low.
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode != mm_pkg::OP_MUL)) |=> !busy)
        else $error("busy raised after element write");

    // A result that is not the final one belongs to a run still in progress.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result while idle");

    // The final result is not followed directly by another result.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result directly after final result");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag without a result");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid),
    .o_last   (o_last)
);
